[rtl/tqps_pkg.sv]
// Shared types and constants for the tone queue PWM sequencer.
package tqps_pkg;

  localparam int unsigned TIMER_W         = 28;
  localparam int unsigned FREQ_W          = 16;
  localparam int unsigned TICKS_W         = 16;
  localparam int unsigned RELOAD_W        = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam logic [TIMER_W-1:0] TIMER_CLK_RESET = TIMER_W'(1000000);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef logic [TIMER_W-1:0] cfg_word_t;

  typedef struct packed {
    logic               op;
    logic [FREQ_W-1:0]  tone_freq_hz;
    logic [TICKS_W-1:0] tone_ticks;
  } in_word_t;

  typedef struct packed {
    logic                pwm_enable;
    logic [RELOAD_W-1:0] reload_value;
    logic [RELOAD_W-1:0] compare_value;
    logic                tone_started;
    logic                push_dropped;
    logic                queue_empty;
  } out_word_t;

  typedef struct packed {
    logic               start;
    logic [TIMER_W-1:0] dividend;
    logic [FREQ_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [RELOAD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/tqps_chan_if.sv]
// Valid/ready channel carrying one word of a given payload type.
interface tqps_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tqps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tqps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/tqps_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle, saturating result.
module tqps_div
  import tqps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(TIMER_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIMER_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TIMER_W-1:0] dvd_r, dvd_nxt;
  logic [FREQ_W-1:0]  dvs_r, dvs_nxt;
  logic [FREQ_W-1:0]  rem_r, rem_nxt;
  logic [RELOAD_W-1:0] quo_r, quo_nxt;
  logic               ovf_r, ovf_nxt;

  logic [FREQ_W:0]    trial;
  logic [FREQ_W:0]    diff;
  logic               q_bit;

  always_comb begin
    trial = {rem_r, dvd_r[TIMER_W-1]};
    diff  = trial - {1'b0, dvs_r};
    q_bit = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      // shift one dividend bit into the partial remainder
      dvd_nxt = {dvd_r[TIMER_W-2:0], 1'b0};
      rem_nxt = q_bit ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      quo_nxt = {quo_r[RELOAD_W-2:0], q_bit};
      ovf_nxt = ovf_r | quo_r[RELOAD_W-1];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = ovf_r ? '1 : quo_r;

endmodule

[rtl/tone_queue_pwm_sequencer_core.sv]
// Top level of the tone queue PWM sequencer: queue control, tick logic, output word.
// A push or a plain tick goes from idle to S_EMIT and then into the output register.
// A tick that dequeues a rest passes S_READ and S_LOAD before S_EMIT; one that dequeues a
// tone also waits in S_DIV for the bit-serial reload divider, one quotient bit per cycle.
// One word at a time: the next word is accepted once the result is in the output register.
// Reset (rst_n, synchronous, active low) empties the queue, stops PWM, clears
// reload to 0 and sets the timer clock to 1 MHz; queue memory contents are not cleared.
module tone_queue_pwm_sequencer_core
  import tqps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tqps_chan_if.sink   in_ch,
  tqps_chan_if.source out_ch,
  tqps_chan_if.sink   cfg_ch
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENT_W = FREQ_W + TICKS_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_DIV,
    S_EMIT
  } state_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [PTR_W-1:0]    pp_r, pp_nxt;
  logic [TICKS_W-1:0]  act_len_r, act_len_nxt;
  logic [TICKS_W-1:0]  elapsed_r, elapsed_nxt;
  logic                pwm_r, pwm_nxt;
  logic [RELOAD_W-1:0] period_r, period_nxt;
  logic [TIMER_W-1:0]  timer_clk_r, timer_clk_nxt;
  logic                started_r, started_nxt;
  logic                dropped_r, dropped_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_r, out_nxt;

  in_word_t            in_word;
  logic                in_fire;
  logic                out_fire;
  logic [PTR_W-1:0]    wr_slot;
  logic                ram_we;
  logic [ENT_W-1:0]    ram_rd;
  logic [FREQ_W-1:0]   rd_freq;
  logic [TICKS_W-1:0]  rd_len;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_word  = in_ch.payload;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  // Take a new word only from idle; the output register may still hold the last result.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Push writes into the slot after the write pointer unless that slot is the play slot.
  assign wr_slot = next_slot(wp_r);
  assign ram_we  = in_fire && (in_word.op == OP_PUSH) && (wr_slot != pp_r);

  tqps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_slot),
    .wr_data ({in_word.tone_freq_hz, in_word.tone_ticks}),
    .rd_addr (pp_r),
    .rd_data (ram_rd)
  );

  assign rd_freq = ram_rd[ENT_W-1:TICKS_W];
  assign rd_len  = ram_rd[TICKS_W-1:0];

  assign div_req.start    = (state_r == S_LOAD) && (rd_freq != '0);
  assign div_req.dividend = timer_clk_r;
  assign div_req.divisor  = rd_freq;

  tqps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    pp_nxt        = pp_r;
    act_len_nxt   = act_len_r;
    elapsed_nxt   = elapsed_r;
    pwm_nxt       = pwm_r;
    period_nxt    = period_r;
    timer_clk_nxt = timer_clk_r;
    started_nxt   = started_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      timer_clk_nxt = cfg_ch.payload;
    end

    // Drain the output register once the sink takes the word.
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          started_nxt = 1'b0;
          dropped_nxt = 1'b0;
          state_nxt   = S_EMIT;
          if (in_word.op == OP_PUSH) begin
            if (wr_slot == pp_r) begin
              dropped_nxt = 1'b1;
            end else begin
              wp_nxt = wr_slot;
            end
          end else if (act_len_r != '0) begin
            // Count the playing tone; stop it on the tick that reaches its length.
            if (elapsed_r == act_len_r) begin
              pwm_nxt     = 1'b0;
              act_len_nxt = '0;
            end else begin
              elapsed_nxt = elapsed_r + TICKS_W'(1);
            end
          end else if (wp_r != pp_r) begin
            // Advance to the next queued tone and fetch it.
            pp_nxt      = next_slot(pp_r);
            started_nxt = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        act_len_nxt = rd_len;
        elapsed_nxt = TICKS_W'(1);
        // A rest leaves PWM and the period as they are.
        state_nxt   = (rd_freq != '0) ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          period_nxt = div_rsp.quotient;
          pwm_nxt    = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.pwm_enable    = pwm_r;
          out_nxt.reload_value  = period_r;
          out_nxt.compare_value = period_r >> 1;
          out_nxt.tone_started  = started_r;
          out_nxt.push_dropped  = dropped_r;
          out_nxt.queue_empty   = (wp_r == pp_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      pp_r        <= '0;
      act_len_r   <= '0;
      elapsed_r   <= '0;
      pwm_r       <= 1'b0;
      period_r    <= '0;
      timer_clk_r <= TIMER_CLK_RESET;
      started_r   <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      pp_r        <= pp_nxt;
      act_len_r   <= act_len_nxt;
      elapsed_r   <= elapsed_nxt;
      pwm_r       <= pwm_nxt;
      period_r    <= period_nxt;
      timer_clk_r <= timer_clk_nxt;
      started_r   <= started_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  a_no_start_and_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.tone_started && out_r.push_dropped))
    else $error("result word flags both a started tone and a dropped push");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_elapsed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (act_len_r != '0) |-> (elapsed_r <= act_len_r))
    else $error("elapsed ticks ran past the tone length");

  a_pwm_start_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pwm_r) |-> ($past(state_r) == S_DIV))
    else $error("PWM started without a reload computation");

  a_queue_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (wp_r != pp_r))
    else $error("push overran the play pointer");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the tone queue PWM sequencer core.
module tb
  import tqps_pkg::*;
();

  // Command word waiting in the driver backlog; a hold word is presented only once
  // every earlier status word has come back.
  typedef struct {
    in_word_t word;
    bit       hold;
  } tone_cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tqps_chan_if #(.payload_t(in_word_t))  in_if ();
  tqps_chan_if #(.payload_t(out_word_t)) out_if ();
  tqps_chan_if #(.payload_t(cfg_word_t)) cfg_if ();

  tone_queue_pwm_sequencer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // Backlog of command words and the status words they must produce.
  tone_cmd_t cmd_backlog[$];
  out_word_t status_due[$];

  // Counters: words queued (blocking, stimulus side), words sent and checked (clocked).
  int unsigned words_total   = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;

  // Idle percentages of the sender and the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Predictor state: tone ring, pointers, playing tone and timer clock.
  bit [FREQ_W-1:0]   slot_freq [QUEUE_DEPTH_DEF];
  bit [TICKS_W-1:0]  slot_len  [QUEUE_DEPTH_DEF];
  int unsigned       wr_ptr    = 0;
  int unsigned       play_ptr  = 0;
  bit [TICKS_W-1:0]  cur_len   = '0;
  bit [TICKS_W-1:0]  elapsed   = '0;
  bit                pwm_on    = 1'b0;
  bit [RELOAD_W-1:0] period    = '0;
  cfg_word_t         timer_clk_model = TIMER_CLK_RESET;

  // Advance the sequencer by one command word and return the status word it yields.
  function automatic out_word_t advance_sequencer(in_word_t w);
    out_word_t   r;
    int unsigned nxt;
    int unsigned quo;
    r = '0;
    if (w.op == OP_PUSH) begin
      // Drop the tone when the slot after the write pointer is the one playing.
      nxt = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
      if (nxt == play_ptr) begin
        r.push_dropped = 1'b1;
      end else begin
        slot_freq[nxt] = w.tone_freq_hz;
        slot_len[nxt]  = w.tone_ticks;
        wr_ptr         = nxt;
      end
    end else if (cur_len != 0) begin
      // Count the playing tone; the tick that ends it starts nothing.
      if (elapsed == cur_len) begin
        pwm_on  = 1'b0;
        cur_len = '0;
      end else begin
        elapsed = elapsed + 1'b1;
      end
    end else if (wr_ptr != play_ptr) begin
      // Dequeue the next tone; a rest leaves PWM and the period alone, and a
      // zero length keeps the tone from ever ending by itself.
      play_ptr = (play_ptr + 1) % QUEUE_DEPTH_DEF;
      cur_len  = slot_len[play_ptr];
      if (slot_freq[play_ptr] != 0) begin
        quo    = timer_clk_model / slot_freq[play_ptr];
        period = (quo > 32'd65535) ? 16'hFFFF : quo[15:0];
        pwm_on = 1'b1;
      end
      elapsed        = TICKS_W'(1);
      r.tone_started = 1'b1;
    end
    r.pwm_enable    = pwm_on;
    r.reload_value  = period;
    r.compare_value = period >> 1;
    r.queue_empty   = (wr_ptr == play_ptr);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: present the head of the backlog, predict each accepted word.
  always @(posedge clk) begin
    logic     nxt_valid;
    in_word_t nxt_word;
    bit       took;
    nxt_valid = in_if.valid;
    nxt_word  = in_if.payload;
    took      = 1'b0;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        status_due.push_back(advance_sequencer(in_if.payload));
        void'(cmd_backlog.pop_front());
        took      = 1'b1;
        nxt_valid = 1'b0;
      end
      // Hold back a hold word until every status word sent so far is checked.
      if (!nxt_valid && cmd_backlog.size() != 0 &&
          $urandom_range(99) >= send_idle_pct &&
          !(cmd_backlog[0].hold && (words_sent + took) != words_checked)) begin
        nxt_valid = 1'b1;
        nxt_word  = cmd_backlog[0].word;
      end
    end
    if (took) begin
      words_sent <= words_sent + 1;
    end
    in_if.valid   <= nxt_valid;
    in_if.payload <= nxt_word;
  end

  // Monitor: stall at random, compare each status word with the oldest prediction.
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    got = out_if.payload;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (status_due.size() == 0) begin
        $error("status word with no prediction waiting");
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("pwm_enable",    want.pwm_enable,    got.pwm_enable);
        check_field("reload_value",  want.reload_value,  got.reload_value);
        check_field("compare_value", want.compare_value, got.compare_value);
        check_field("tone_started",  want.tone_started,  got.tone_started);
        check_field("push_dropped",  want.push_dropped,  got.push_dropped);
        check_field("queue_empty",   want.queue_empty,   got.queue_empty);
      end
      words_checked <= words_checked + 1;
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic add_cmd(input logic op, input int unsigned freq, input int unsigned ticks,
                         input bit hold);
    tone_cmd_t c;
    c.word.op           = op;
    c.word.tone_freq_hz = freq[FREQ_W-1:0];
    c.word.tone_ticks   = ticks[TICKS_W-1:0];
    c.hold              = hold;
    cmd_backlog.push_back(c);
    words_total++;
  endtask

  // Write the timer clock register; call only while the core is idle.
  task automatic write_timer_clock(input cfg_word_t val);
    @(posedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid    <= 1'b0;
    timer_clk_model  = val;
  endtask

  // Wait until every queued word has its status checked, then let the core settle.
  task automatic wait_drained();
    while (words_checked != words_total) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random frequency: rests, both extremes, low tones and full-range values.
  function automatic int unsigned pick_freq();
    case ($urandom_range(9))
      0, 1:    return 0;
      2:       return 1;
      3:       return 16'hFFFF;
      4, 5:    return $urandom_range(1, 200);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Random length: mostly short so tones finish, zero length often, long rarely.
  function automatic int unsigned pick_ticks(input bit allow_long);
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 3);
      6, 7:             return 0;
      8, 9, 10, 11, 12: return $urandom_range(4, 12);
      13, 14, 15:       return $urandom_range(13, 60);
      16:               return $urandom_range(61, 250);
      17:               return (allow_long && $urandom_range(9) == 0) ?
                               $urandom_range(0, 16'hFFFF) : $urandom_range(1, 2);
      default:          return $urandom_range(1, 6);
    endcase
  endfunction

  // Queue bursts of pushes and ticks; long push bursts overflow the ring.
  task automatic queue_random_words(input int unsigned n_words, input bit allow_long);
    int unsigned made;
    int unsigned burst;
    bit          pushing;
    made = 0;
    while (made < n_words) begin
      pushing = ($urandom_range(99) < 35);
      if (pushing) begin
        burst = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
      end else begin
        burst = $urandom_range(1, 25);
      end
      repeat (burst) begin
        if (made < n_words) begin
          // Tick words carry random payload too; the core must ignore it.
          add_cmd(pushing ? OP_PUSH : OP_TICK, pick_freq(), pick_ticks(allow_long),
                  made == 0 || $urandom_range(49) == 0);
          made++;
        end
      end
    end
  endtask

  initial begin
    cfg_word_t seg_clk [6];
    int unsigned seg;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;

    // Hold reset, then release it.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset timer clock, sender 17 / receiver 59 idle.
    send_idle_pct = 17;
    recv_idle_pct = 59;
    write_timer_clock(TIMER_CLK_RESET);
    @(negedge clk);
    add_cmd(OP_TICK, 0, 0, 1'b0);          // tick on an empty ring
    add_cmd(OP_PUSH, 1000, 2, 1'b0);       // plain tone
    add_cmd(OP_PUSH, 0, 1, 1'b0);          // rest
    add_cmd(OP_PUSH, 1, 0, 1'b0);          // zero length, reload saturates
    add_cmd(OP_PUSH, 16'hFFFF, 1, 1'b0);   // highest frequency
    repeat (11) add_cmd(OP_PUSH, $urandom_range(1, 5000), $urandom_range(0, 3), 1'b0);
    add_cmd(OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b0);  // ring full: dropped
    add_cmd(OP_PUSH, 0, 0, 1'b0);                // dropped as well
    repeat (8) add_cmd(OP_TICK, 0, 0, 1'b0);     // play through the first tones
    wait_drained();

    // Random part: one timer clock per segment, extremes included.
    seg_clk[0] = TIMER_W'(200000000);
    seg_clk[1] = TIMER_W'(1);
    seg_clk[2] = TIMER_W'($urandom_range(1, 200000000));
    seg_clk[3] = TIMER_W'(65535);
    seg_clk[4] = TIMER_W'($urandom_range(100000, 20000000));
    seg_clk[5] = TIMER_CLK_RESET;
    for (seg = 0; seg < 6; seg++) begin
      write_timer_clock(seg_clk[seg]);
      @(negedge clk);
      // Swap the idle mix after two segments, drop idling for the last two.
      if (seg < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 59;
      end else if (seg < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_random_words(134, seg == 5);
      wait_drained();
    end

    if (status_due.size() != 0) begin
      $error("%0d predicted status words never arrived", status_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Abort a hung run.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/tqps_pkg.sv
rtl/tqps_chan_if.sv
rtl/tqps_ram.sv
rtl/tqps_div.sv
rtl/tone_queue_pwm_sequencer_core.sv
tb/sv/tb.sv
